[rtl/core/pwmp_pkg.sv]
// ---------------------------------------------------------------------------
// pwmp_pkg
// Shared types, codes and helpers of the peer wire message parser.
// ---------------------------------------------------------------------------
`default_nettype none

package pwmp_pkg;

   // default number of pieces the bitmap can hold
   localparam int unsigned MAX_PIECES_DEFAULT = 4096;

   // handshake protocol identifier
   localparam logic [7:0]   PROTO_LEN  = 8'd19;
   localparam logic [151:0] PROTO_TEXT = "BitTorrent protocol";

   // default message length limit
   localparam logic [31:0] DEFAULT_MAX_LEN = 32'd200000;

   // handshake byte positions
   localparam logic [31:0] HS_PROTO_END = 32'd19;
   localparam logic [31:0] HS_HASH_BEG  = 32'd28;
   localparam logic [31:0] HS_HASH_END  = 32'd47;
   localparam logic [31:0] HS_ID_BEG    = 32'd48;
   localparam logic [31:0] HS_ID_END    = 32'd67;

   // parse phases
   localparam logic [1:0] PH_HANDSHAKE = 2'd0;
   localparam logic [1:0] PH_LENGTH    = 2'd1;
   localparam logic [1:0] PH_MESSAGE   = 2'd2;

   // message ids
   localparam logic [7:0] MSG_CHOKE      = 8'd0;
   localparam logic [7:0] MSG_UNCHOKE    = 8'd1;
   localparam logic [7:0] MSG_INTERESTED = 8'd2;
   localparam logic [7:0] MSG_NOT_INTER  = 8'd3;
   localparam logic [7:0] MSG_HAVE       = 8'd4;
   localparam logic [7:0] MSG_BITFIELD   = 8'd5;
   localparam logic [7:0] MSG_REQUEST    = 8'd6;
   localparam logic [7:0] MSG_PIECE      = 8'd7;
   localparam logic [7:0] MSG_CANCEL     = 8'd8;

   // event codes
   localparam logic [3:0] EV_HANDSHAKE_OK = 4'd0;
   localparam logic [3:0] EV_KEEPALIVE    = 4'd1;
   localparam logic [3:0] EV_CHOKED       = 4'd2;
   localparam logic [3:0] EV_UNCHOKED     = 4'd3;
   localparam logic [3:0] EV_INTERESTED   = 4'd4;
   localparam logic [3:0] EV_NOT_INTER    = 4'd5;
   localparam logic [3:0] EV_HAVE         = 4'd6;
   localparam logic [3:0] EV_BITFIELD     = 4'd7;
   localparam logic [3:0] EV_REQUEST      = 4'd8;
   localparam logic [3:0] EV_PIECE_START  = 4'd9;
   localparam logic [3:0] EV_PIECE_DATA   = 4'd10;
   localparam logic [3:0] EV_CANCEL       = 4'd11;
   localparam logic [3:0] EV_ABORT        = 4'd12;

   // abort reasons
   localparam logic [1:0] AB_BAD_PROTO  = 2'd0;
   localparam logic [1:0] AB_HASH       = 2'd1;
   localparam logic [1:0] AB_SELF       = 2'd2;
   localparam logic [1:0] AB_TOO_LONG   = 2'd3;

   // register indexes
   localparam logic [2:0] CSR_HASH_HIGH = 3'd0;
   localparam logic [2:0] CSR_HASH_MID  = 3'd1;
   localparam logic [2:0] CSR_HASH_LOW  = 3'd2;
   localparam logic [2:0] CSR_ID_HIGH   = 3'd3;
   localparam logic [2:0] CSR_ID_MID    = 3'd4;
   localparam logic [2:0] CSR_ID_LOW    = 3'd5;
   localparam logic [2:0] CSR_PIECES    = 3'd6;
   localparam logic [2:0] CSR_MAX_LEN   = 3'd7;

   // one result item
   typedef struct packed {
      logic [3:0]  event_code;
      logic [31:0] piece_index;
      logic [31:0] block_begin;
      logic [31:0] block_length;
      logic [7:0]  data_byte;
      logic        data_last;
      logic [1:0]  abort_reason;
      logic        choked_by_peer;
      logic        peer_interested;
   } rsp_type;

   // byte k (0 first) of a 20-byte key stored big-endian
   function automatic logic [7:0] key_byte(input logic [159:0] key, input logic [4:0] k);
      logic [159:0] sh;
      sh = key >> {5'd19 - k, 3'b000};
      return sh[7:0];
   endfunction

   // byte k (0 first) of the protocol string
   function automatic logic [7:0] proto_byte(input logic [4:0] k);
      logic [151:0] sh;
      sh = PROTO_TEXT >> {5'd18 - k, 3'b000};
      return sh[7:0];
   endfunction

endpackage

`default_nettype wire

[rtl/core/pwmp_req_if.sv]
// ---------------------------------------------------------------------------
// pwmp_req_if
// Received byte channel with valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface pwmp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[rtl/core/pwmp_rsp_if.sv]
// ---------------------------------------------------------------------------
// pwmp_rsp_if
// Parser event channel with valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface pwmp_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  event_code;
   logic [31:0] piece_index;
   logic [31:0] block_begin;
   logic [31:0] block_length;
   logic [7:0]  data_byte;
   logic        data_last;
   logic [1:0]  abort_reason;
   logic        choked_by_peer;
   logic        peer_interested;

   modport source (output valid, output event_code, output piece_index,
                   output block_begin, output block_length, output data_byte,
                   output data_last, output abort_reason, output choked_by_peer,
                   output peer_interested, input ready);
   modport sink   (input valid, input event_code, input piece_index,
                   input block_begin, input block_length, input data_byte,
                   input data_last, input abort_reason, input choked_by_peer,
                   input peer_interested, output ready);
endinterface

`default_nettype wire

[rtl/core/pwmp_bitmap.sv]
// ---------------------------------------------------------------------------
// pwmp_bitmap
// Piece bitmap memory: read-modify-write bit set with forwarding, and a
// clearing pass after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module pwmp_bitmap #(
   parameter int unsigned DEPTH = 512,
   parameter int unsigned AW    = 9
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          set_en,
   input  wire logic [AW-1:0] set_addr,
   input  wire logic [7:0]    set_mask,
   output      logic          clear_busy
);

   logic [7:0] mem [DEPTH];

   // clearing pass state
   logic          clr_busy_ff, clr_busy_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   // write stage
   logic          wr_valid_ff;
   logic [AW-1:0] wr_addr_ff;
   logic [7:0]    wr_mask_ff;
   logic [7:0]    rd_data_ff;
   logic          fwd_ff;
   logic [7:0]    fwd_data_ff;
   logic [7:0]    wr_data;

   assign clear_busy = clr_busy_ff;

   // merge read data, or the write that landed with the read, with the new bits
   assign wr_data = (fwd_ff ? fwd_data_ff : rd_data_ff) | wr_mask_ff;

   // clear sweep control
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == AW'(DEPTH - 1)) clr_busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
         wr_valid_ff <= 1'b0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
         wr_valid_ff <= set_en && !clr_busy_ff;
      end
   end

   // read stage and forwarding capture
   always_ff @(posedge clock) begin
      rd_data_ff  <= mem[set_addr];
      wr_addr_ff  <= set_addr;
      wr_mask_ff  <= set_mask;
      fwd_ff      <= wr_valid_ff && (wr_addr_ff == set_addr);
      fwd_data_ff <= wr_data;
   end

   // memory write port
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= 8'h00;
      end else if (wr_valid_ff) begin
         mem[wr_addr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

[rtl/core/peer_wire_message_parser_core.sv]
// ---------------------------------------------------------------------------
// peer_wire_message_parser_core
// Receive-side peer wire parser: handshake check, message deframing, events.
// ---------------------------------------------------------------------------
// The block takes one received byte per cycle and gives at most one event per
// byte, through an output register with a skid stage, so a byte is taken
// every cycle while the event side keeps up. All parse state updates within
// the cycle of the byte; the piece bitmap lives in a memory updated by a
// read-modify-write (read stage, then write stage) with forwarding. After
// reset the bitmap is swept to zero, one row per cycle over its MAX_PIECES/8
// rounded up rows (512 at the default), during which no byte is taken.
`default_nettype none

module peer_wire_message_parser_core #(
   parameter int unsigned MAX_PIECES = pwmp_pkg::MAX_PIECES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   pwmp_req_if.sink         req_chan,
   pwmp_rsp_if.source       rsp_chan,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);

   localparam int unsigned DEPTH = (MAX_PIECES + 7) / 8;
   localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // configuration registers
   logic [159:0] hash_ff;
   logic [159:0] own_id_ff;
   logic [12:0]  piece_count_ff;
   logic [31:0]  max_len_ff;

   // parse state
   logic [1:0]  phase_ff, phase_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] msg_len_ff, msg_len_in;
   logic [7:0]  msg_id_ff, msg_id_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] index_ff, index_in;
   logic [31:0] begin_ff, begin_in;
   logic        match_ff, match_in;
   logic        choked_ff, choked_in;
   logic        inter_ff, inter_in;
   logic        aborted_ff, aborted_in;

   // output register and skid stage
   logic              out_valid_ff;
   pwmp_pkg::rsp_type out_ff;
   logic              skid_valid_ff;
   pwmp_pkg::rsp_type skid_ff;

   logic              res_valid;
   pwmp_pkg::rsp_type res;
   logic              set_en;
   logic [AW-1:0]     set_addr;
   logic [7:0]        set_mask;
   logic              clear_busy;
   logic              accept;

   // piece limit and helper values
   logic [31:0] lim;
   logic [31:0] lim_row;
   logic [7:0]  lim_mask;
   logic [31:0] pos;
   logic [31:0] row;
   logic        last;
   logic [31:0] dlen;
   logic [31:0] lane;
   logic [7:0]  rev_b;
   logic [7:0]  b;

   // assembled length value from the three held bytes and the current one
   function automatic logic [31:0] acc_in_len(input logic [31:0] acc, input logic [7:0] nb);
      return {acc[23:0], nb};
   endfunction

   assign b      = req_chan.rx_byte;
   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !clear_busy && !skid_valid_ff;

   assign lim = (32'(piece_count_ff) < 32'(MAX_PIECES)) ? 32'(piece_count_ff)
                                                        : 32'(MAX_PIECES);
   assign lim_row  = lim >> 3;
   assign lim_mask = 8'((9'd1 << lim[2:0]) - 9'd1);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff        <= '0;
         own_id_ff      <= '0;
         piece_count_ff <= '0;
         max_len_ff     <= pwmp_pkg::DEFAULT_MAX_LEN;
      end else if (csr_we) begin
         unique case (csr_index)
            pwmp_pkg::CSR_HASH_HIGH: hash_ff[159:96]   <= csr_wdata;
            pwmp_pkg::CSR_HASH_MID:  hash_ff[95:32]    <= csr_wdata;
            pwmp_pkg::CSR_HASH_LOW:  hash_ff[31:0]     <= csr_wdata[31:0];
            pwmp_pkg::CSR_ID_HIGH:   own_id_ff[159:96] <= csr_wdata;
            pwmp_pkg::CSR_ID_MID:    own_id_ff[95:32]  <= csr_wdata;
            pwmp_pkg::CSR_ID_LOW:    own_id_ff[31:0]   <= csr_wdata[31:0];
            pwmp_pkg::CSR_PIECES:    piece_count_ff    <= csr_wdata[12:0];
            pwmp_pkg::CSR_MAX_LEN:   max_len_ff        <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // per-byte parse step
   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      msg_len_in = msg_len_ff;
      msg_id_in  = msg_id_ff;
      acc_in     = acc_ff;
      index_in   = index_ff;
      begin_in   = begin_ff;
      match_in   = match_ff;
      choked_in  = choked_ff;
      inter_in   = inter_ff;
      aborted_in = aborted_ff;
      res_valid  = 1'b0;
      res        = '0;
      set_en     = 1'b0;
      set_addr   = '0;
      set_mask   = '0;
      pos        = count_ff;
      last       = (count_ff == msg_len_ff - 32'd1);
      dlen       = (msg_len_ff > 32'd9) ? msg_len_ff - 32'd9 : 32'd0;
      lane       = count_ff - 32'd1;
      row        = count_ff - 32'd1;
      for (int k = 0; k < 8; k++) rev_b[k] = b[7-k];

      if (aborted_ff) begin
         // sticky abort: bytes are dropped
      end else if (phase_ff == pwmp_pkg::PH_LENGTH) begin
         acc_in   = {acc_ff[23:0], b};
         count_in = count_ff + 32'd1;
         if (count_ff[1:0] == 2'd3) begin
            count_in = '0;
            acc_in   = '0;
            if (acc_in_len(acc_ff, b) > max_len_ff) begin
               aborted_in       = 1'b1;
               res_valid        = 1'b1;
               res.event_code   = pwmp_pkg::EV_ABORT;
               res.abort_reason = pwmp_pkg::AB_TOO_LONG;
            end else if (acc_in_len(acc_ff, b) == 32'd0) begin
               res_valid      = 1'b1;
               res.event_code = pwmp_pkg::EV_KEEPALIVE;
            end else begin
               msg_len_in = acc_in_len(acc_ff, b);
               phase_in   = pwmp_pkg::PH_MESSAGE;
            end
         end
      end else if (phase_ff == pwmp_pkg::PH_MESSAGE) begin
         // field capture
         if (pos == 32'd0) begin
            msg_id_in = b;
            index_in  = '0;
            begin_in  = '0;
            acc_in    = '0;
         end else if (pos <= 32'd12) begin
            case (lane[3:2])
               2'd0: case (lane[1:0])
                  2'd0: index_in[31:24] = b;
                  2'd1: index_in[23:16] = b;
                  2'd2: index_in[15:8]  = b;
                  default: index_in[7:0] = b;
               endcase
               2'd1: case (lane[1:0])
                  2'd0: begin_in[31:24] = b;
                  2'd1: begin_in[23:16] = b;
                  2'd2: begin_in[15:8]  = b;
                  default: begin_in[7:0] = b;
               endcase
               default: case (lane[1:0])
                  2'd0: acc_in[31:24] = b;
                  2'd1: acc_in[23:16] = b;
                  2'd2: acc_in[15:8]  = b;
                  default: acc_in[7:0] = b;
               endcase
            endcase
         end

         // bitfield payload sets one bitmap row
         if (msg_id_ff == pwmp_pkg::MSG_BITFIELD && pos != 32'd0) begin
            set_addr = row[AW-1:0];
            if (row < lim_row) begin
               set_mask = rev_b;
            end else if (row == lim_row) begin
               set_mask = rev_b & lim_mask;
            end
            set_en = (set_mask != 8'h00);
         end

         if (msg_id_in == pwmp_pkg::MSG_PIECE) begin
            res.piece_index  = index_in;
            res.block_begin  = begin_in;
            res.block_length = dlen;
            if (pos >= 32'd9) begin
               res_valid      = 1'b1;
               res.event_code = pwmp_pkg::EV_PIECE_DATA;
               res.data_byte  = b;
               res.data_last  = last;
            end else if (pos == 32'd8 || last) begin
               res_valid      = 1'b1;
               res.event_code = pwmp_pkg::EV_PIECE_START;
            end
         end else if (last) begin
            case (msg_id_in)
               pwmp_pkg::MSG_CHOKE: begin
                  choked_in = 1'b1;
                  res_valid = 1'b1;
                  res.event_code = pwmp_pkg::EV_CHOKED;
               end
               pwmp_pkg::MSG_UNCHOKE: begin
                  choked_in = 1'b0;
                  res_valid = 1'b1;
                  res.event_code = pwmp_pkg::EV_UNCHOKED;
               end
               pwmp_pkg::MSG_INTERESTED: begin
                  inter_in  = 1'b1;
                  res_valid = 1'b1;
                  res.event_code = pwmp_pkg::EV_INTERESTED;
               end
               pwmp_pkg::MSG_NOT_INTER: begin
                  inter_in  = 1'b0;
                  res_valid = 1'b1;
                  res.event_code = pwmp_pkg::EV_NOT_INTER;
               end
               pwmp_pkg::MSG_HAVE: begin
                  res_valid       = 1'b1;
                  res.event_code  = pwmp_pkg::EV_HAVE;
                  res.piece_index = index_in;
                  set_en          = (index_in < lim);
                  set_addr        = index_in[AW+2:3];
                  set_mask        = 8'(9'd1 << index_in[2:0]);
               end
               pwmp_pkg::MSG_BITFIELD: begin
                  res_valid      = 1'b1;
                  res.event_code = pwmp_pkg::EV_BITFIELD;
               end
               pwmp_pkg::MSG_REQUEST: begin
                  res_valid        = 1'b1;
                  res.event_code   = pwmp_pkg::EV_REQUEST;
                  res.piece_index  = index_in;
                  res.block_begin  = begin_in;
                  res.block_length = acc_in;
               end
               pwmp_pkg::MSG_CANCEL: begin
                  res_valid        = 1'b1;
                  res.event_code   = pwmp_pkg::EV_CANCEL;
                  res.piece_index  = index_in;
                  res.block_begin  = begin_in;
                  res.block_length = acc_in;
               end
               default: ;
            endcase
         end

         if (last) begin
            phase_in = pwmp_pkg::PH_LENGTH;
            count_in = '0;
            acc_in   = '0;
         end else begin
            count_in = count_ff + 32'd1;
         end
      end else begin
         // handshake
         count_in = count_ff + 32'd1;
         if (pos == 32'd0) begin
            match_in = (b == pwmp_pkg::PROTO_LEN);
         end else if (pos <= pwmp_pkg::HS_PROTO_END) begin
            if (b != pwmp_pkg::proto_byte(5'(pos - 32'd1))) match_in = 1'b0;
            if (pos == pwmp_pkg::HS_PROTO_END) begin
               if (!match_in) begin
                  aborted_in       = 1'b1;
                  res_valid        = 1'b1;
                  res.event_code   = pwmp_pkg::EV_ABORT;
                  res.abort_reason = pwmp_pkg::AB_BAD_PROTO;
               end
               match_in = 1'b1;
            end
         end else if (pos >= pwmp_pkg::HS_HASH_BEG && pos <= pwmp_pkg::HS_HASH_END) begin
            if (b != pwmp_pkg::key_byte(hash_ff, 5'(pos - pwmp_pkg::HS_HASH_BEG)))
               match_in = 1'b0;
            if (pos == pwmp_pkg::HS_HASH_END) begin
               if (!match_in) begin
                  aborted_in       = 1'b1;
                  res_valid        = 1'b1;
                  res.event_code   = pwmp_pkg::EV_ABORT;
                  res.abort_reason = pwmp_pkg::AB_HASH;
               end
               match_in = 1'b1;
            end
         end else if (pos >= pwmp_pkg::HS_ID_BEG) begin
            if (b != pwmp_pkg::key_byte(own_id_ff, 5'(pos - pwmp_pkg::HS_ID_BEG)))
               match_in = 1'b0;
            if (pos >= pwmp_pkg::HS_ID_END) begin
               res_valid = 1'b1;
               if (match_in) begin
                  aborted_in       = 1'b1;
                  res.event_code   = pwmp_pkg::EV_ABORT;
                  res.abort_reason = pwmp_pkg::AB_SELF;
               end else begin
                  res.event_code = pwmp_pkg::EV_HANDSHAKE_OK;
                  phase_in       = pwmp_pkg::PH_LENGTH;
                  count_in       = '0;
                  acc_in         = '0;
               end
               match_in = 1'b1;
            end
         end
      end

      res.choked_by_peer  = choked_in;
      res.peer_interested = inter_in;
   end

   // parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= pwmp_pkg::PH_HANDSHAKE;
         count_ff   <= '0;
         msg_len_ff <= '0;
         msg_id_ff  <= '0;
         acc_ff     <= '0;
         index_ff   <= '0;
         begin_ff   <= '0;
         match_ff   <= 1'b1;
         choked_ff  <= 1'b1;
         inter_ff   <= 1'b0;
         aborted_ff <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         msg_len_ff <= msg_len_in;
         msg_id_ff  <= msg_id_in;
         acc_ff     <= acc_in;
         index_ff   <= index_in;
         begin_ff   <= begin_in;
         match_ff   <= match_in;
         choked_ff  <= choked_in;
         inter_ff   <= inter_in;
         aborted_ff <= aborted_in;
      end
   end

   // output register with skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_chan.ready) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept && res_valid;
         end
      end else if (accept && res_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_chan.ready) begin
         out_ff <= skid_valid_ff ? skid_ff : res;
      end else if (accept && res_valid) begin
         skid_ff <= res;
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.event_code      = out_ff.event_code;
   assign rsp_chan.piece_index     = out_ff.piece_index;
   assign rsp_chan.block_begin     = out_ff.block_begin;
   assign rsp_chan.block_length    = out_ff.block_length;
   assign rsp_chan.data_byte       = out_ff.data_byte;
   assign rsp_chan.data_last       = out_ff.data_last;
   assign rsp_chan.abort_reason    = out_ff.abort_reason;
   assign rsp_chan.choked_by_peer  = out_ff.choked_by_peer;
   assign rsp_chan.peer_interested = out_ff.peer_interested;

   // piece bitmap
   pwmp_bitmap #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_bitmap (
      .clock      (clock),
      .reset      (reset),
      .set_en     (set_en && accept),
      .set_addr   (set_addr),
      .set_mask   (set_mask),
      .clear_busy (clear_busy)
   );

endmodule

`default_nettype wire
